### hw/rtl/trsa_pkg.sv
// ----------------------------------------------------------------------------
// trsa_pkg
// Shared types and constants of the textbook rsa exponentiation block:
// controller states, datapath micro-operations, command and status bundles.
// ----------------------------------------------------------------------------
package trsa_pkg;

    // default widths and fixed field widths
    localparam int PRIME_BITS_DEF = 16;
    localparam int MOD_BITS_DEF   = 32;
    localparam int VALUE_BITS     = 32;
    localparam int CFG_IDX_BITS   = 2;

    // primes after reset
    localparam int RESET_P = 61;
    localparam int RESET_Q = 53;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_P = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Q = 2'd1;

    // controller states
    typedef enum logic [4:0] {
        S_KEY_N,
        S_KEY_PHI,
        S_E_INIT,
        S_GCD_INIT,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_D_CHK,
        S_INV_TEST,
        S_INV_DIV,
        S_INV_MUL,
        S_IDLE,
        S_ITEM,
        S_RED_WAIT,
        S_BIT,
        S_SQ_WAIT,
        S_MB_CHK,
        S_MB_WAIT,
        S_SHIFT,
        S_DONE
    } t_state;

    // datapath register operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CALC_N,
        OP_CALC_PHI,
        OP_E_INIT,
        OP_E_NEXT,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_D_ZERO,
        OP_INV_INIT,
        OP_INV_STEP,
        OP_INV_DONE,
        OP_ITEM_LOAD,
        OP_EXP_INIT,
        OP_EXP_FIRST,
        OP_ACC_MM,
        OP_EXP_SHIFT
    } t_dp_op;

    // divider operand select
    typedef enum logic {
        DIV_XY,
        DIV_VAL
    } t_div_sel;

    // modular multiplier operand select
    typedef enum logic [1:0] {
        MM_SQ,
        MM_BASE,
        MM_INV
    } t_mm_sel;

    typedef struct packed {
        t_dp_op   op;
        logic     div_start;
        t_div_sel div_sel;
        logic     mm_start;
        t_mm_sel  mm_sel;
        logic     result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic phi_le1;
        logic phi_le2;
        logic n_gt1;
        logic y_zero;
        logic x_one;
        logic exp_bit;
        logic started;
        logic cnt_zero;
        logic div_done;
        logic mm_done;
    } t_dp_stat;

endpackage

### hw/rtl/trsa_div.sv
// ----------------------------------------------------------------------------
// trsa_div
// Restoring radix-2 divider, one quotient bit per cycle; quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module trsa_div #(
    parameter int DIV_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_num,
    input  logic [DIV_BITS-1:0] i_den,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quo,
    output logic [DIV_BITS-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [DIV_BITS-1:0] r_rem, n_rem;
    logic [DIV_BITS-1:0] r_den, n_den;
    logic [DIV_BITS:0]   sh;
    logic                ge;

    // one shift and trial subtract
    always_comb begin
        sh     = {r_rem, r_quo[DIV_BITS-1]};
        ge     = (sh >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(DIV_BITS);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? DIV_BITS'(sh - {1'b0, r_den}) : DIV_BITS'(sh);
            n_quo = {r_quo[DIV_BITS-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### hw/rtl/trsa_mulmod.sv
// ----------------------------------------------------------------------------
// trsa_mulmod
// Bit-serial modular multiplier: double-and-add over the multiplier bits,
// msb first, with both operands below the modulus.
// ----------------------------------------------------------------------------
module trsa_mulmod #(
    parameter int MOD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_x,
    input  logic [MOD_BITS-1:0] i_y,
    input  logic [MOD_BITS-1:0] i_m,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_prod
);

    localparam int CNT_BITS = $clog2(MOD_BITS + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [MOD_BITS-1:0] r_x, n_x;
    logic [MOD_BITS-1:0] r_y, n_y;
    logic [MOD_BITS-1:0] r_m, n_m;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS:0]   s1, s2;
    logic [MOD_BITS-1:0] a1, a2;

    // double, then conditionally add, each reduced once
    always_comb begin
        s1 = {1'b0, r_acc} + {1'b0, r_acc};
        a1 = (s1 >= {1'b0, r_m}) ? MOD_BITS'(s1 - {1'b0, r_m}) : MOD_BITS'(s1);
        s2 = {1'b0, a1} + {1'b0, r_x};
        a2 = (s2 >= {1'b0, r_m}) ? MOD_BITS'(s2 - {1'b0, r_m}) : MOD_BITS'(s2);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_m    = r_m;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(MOD_BITS);
            n_x    = i_x;
            n_y    = i_y;
            n_m    = i_m;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = r_y[MOD_BITS-1] ? a2 : a1;
            n_y   = r_y << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_m   <= n_m;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hw/rtl/trsa_dp.sv
// ----------------------------------------------------------------------------
// trsa_dp
// Datapath: prime registers, key registers, euclid and exponentiation
// working registers, shared divider and shared modular multiplier.
// ----------------------------------------------------------------------------
module trsa_dp #(
    parameter int PRIME_BITS = 16,
    parameter int MOD_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trsa_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [PRIME_BITS-1:0]              i_cfg_data,
    input  logic                               i_operation,
    input  logic [trsa_pkg::VALUE_BITS-1:0]    i_value,
    input  logic                               i_last_in_message,
    input  trsa_pkg::t_dp_cmd                  i_cmd,
    output trsa_pkg::t_dp_stat                 o_stat,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_result_value,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_public_exponent,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_private_exponent,
    output logic                               o_last_of_message
);
    import trsa_pkg::*;

    localparam int DIV_BITS = (MOD_BITS > VALUE_BITS) ? MOD_BITS : VALUE_BITS;
    localparam int CNT_BITS = $clog2(MOD_BITS + 1);

    logic [PRIME_BITS-1:0]   r_p, r_q;
    logic [MOD_BITS-1:0]     r_n, r_phi, r_e, r_d;
    logic [MOD_BITS-1:0]     r_x, r_y, r_t0, r_t1;
    logic [MOD_BITS-1:0]     r_acc, r_base, r_exp;
    logic [CNT_BITS-1:0]     r_cnt;
    logic                    r_started;
    logic                    r_op, r_last;
    logic [VALUE_BITS-1:0]   r_val;
    logic [VALUE_BITS-1:0]   r_res, r_res_e, r_res_d;
    logic                    r_res_last;

    logic [PRIME_BITS-1:0]   pm, qm, mul_a, mul_b;
    logic [2*PRIME_BITS-1:0] prod;
    logic [DIV_BITS-1:0]     div_num, div_den, div_quo, div_rem;
    logic                    div_done;
    logic [MOD_BITS-1:0]     qt, qt_red, mm_x, mm_y, mm_m, mm_prod, tn;
    logic                    mm_done;
    logic                    cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_P || i_cfg_index == REG_Q);

    // key products, one shared multiplier
    assign pm    = (r_p >= PRIME_BITS'(2)) ? r_p - 1'b1 : '0;
    assign qm    = (r_q >= PRIME_BITS'(2)) ? r_q - 1'b1 : '0;
    assign mul_a = (i_cmd.op == OP_CALC_N) ? r_p : pm;
    assign mul_b = (i_cmd.op == OP_CALC_N) ? r_q : qm;
    assign prod  = mul_a * mul_b;

    // divider operands
    assign div_num = (i_cmd.div_sel == DIV_VAL) ? DIV_BITS'(r_val) : DIV_BITS'(r_x);
    assign div_den = (i_cmd.div_sel == DIV_VAL) ? DIV_BITS'(r_n) : DIV_BITS'(r_y);

    trsa_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // euclid quotient reduced below phi
    assign qt     = MOD_BITS'(div_quo);
    assign qt_red = (qt >= r_phi) ? qt - r_phi : qt;

    // multiplier operands
    always_comb begin
        unique case (i_cmd.mm_sel)
            MM_SQ: begin
                mm_x = r_acc;
                mm_y = r_acc;
                mm_m = r_n;
            end
            MM_BASE: begin
                mm_x = r_acc;
                mm_y = r_base;
                mm_m = r_n;
            end
            default: begin
                mm_x = qt_red;
                mm_y = r_t1;
                mm_m = r_phi;
            end
        endcase
    end

    trsa_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    // next bezout coefficient, t0 - q*t1 mod phi
    assign tn = (r_t0 >= mm_prod) ? r_t0 - mm_prod : r_t0 + (r_phi - mm_prod);

    // configuration and exponent start flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p       <= PRIME_BITS'(RESET_P);
            r_q       <= PRIME_BITS'(RESET_Q);
            r_started <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_P) begin
                r_p <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_Q) begin
                r_q <= i_cfg_data;
            end
            if (i_cmd.op == OP_EXP_INIT) begin
                r_started <= 1'b0;
            end else if (i_cmd.op == OP_EXP_FIRST && r_exp[MOD_BITS-1]) begin
                r_started <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_CALC_N: begin
                r_n <= MOD_BITS'(prod);
            end
            OP_CALC_PHI: begin
                r_phi <= MOD_BITS'(prod);
            end
            OP_E_INIT: begin
                r_e <= MOD_BITS'(2);
            end
            OP_E_NEXT: begin
                r_e <= r_e + 1'b1;
            end
            OP_GCD_INIT: begin
                r_x <= r_phi;
                r_y <= r_e;
            end
            OP_GCD_STEP: begin
                r_x <= r_y;
                r_y <= MOD_BITS'(div_rem);
            end
            OP_D_ZERO: begin
                r_d <= '0;
            end
            OP_INV_INIT: begin
                r_x  <= r_phi;
                r_y  <= (r_e >= r_phi) ? r_e - r_phi : r_e;
                r_t0 <= '0;
                r_t1 <= MOD_BITS'(1);
            end
            OP_INV_STEP: begin
                r_x  <= r_y;
                r_y  <= MOD_BITS'(div_rem);
                r_t0 <= r_t1;
                r_t1 <= tn;
            end
            OP_INV_DONE: begin
                r_d <= (r_x == MOD_BITS'(1)) ? r_t0 : '0;
            end
            OP_ITEM_LOAD: begin
                r_op   <= i_operation;
                r_val  <= i_value;
                r_last <= i_last_in_message;
            end
            OP_EXP_INIT: begin
                r_base <= MOD_BITS'(div_rem);
                r_acc  <= MOD_BITS'(1);
                r_exp  <= r_op ? r_d : r_e;
                r_cnt  <= CNT_BITS'(MOD_BITS);
            end
            OP_EXP_FIRST: begin
                if (r_exp[MOD_BITS-1]) begin
                    r_acc <= r_base;
                end
                r_exp <= r_exp << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_ACC_MM: begin
                r_acc <= mm_prod;
            end
            OP_EXP_SHIFT: begin
                r_exp <= r_exp << 1;
                r_cnt <= r_cnt - 1'b1;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_res      <= (r_n > MOD_BITS'(1)) ? VALUE_BITS'(r_acc) : '0;
            r_res_e    <= VALUE_BITS'(r_e);
            r_res_d    <= VALUE_BITS'(r_d);
            r_res_last <= r_last;
        end
    end

    // status to controller
    always_comb begin
        o_stat.cfg_hit  = cfg_hit;
        o_stat.phi_le1  = (r_phi <= MOD_BITS'(1));
        o_stat.phi_le2  = (r_phi <= MOD_BITS'(2));
        o_stat.n_gt1    = (r_n > MOD_BITS'(1));
        o_stat.y_zero   = (r_y == '0);
        o_stat.x_one    = (r_x == MOD_BITS'(1));
        o_stat.exp_bit  = r_exp[MOD_BITS-1];
        o_stat.started  = r_started;
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.div_done = div_done;
        o_stat.mm_done  = mm_done;
    end

    assign o_result_value     = r_res;
    assign o_public_exponent  = r_res_e;
    assign o_private_exponent = r_res_d;
    assign o_last_of_message  = r_res_last;

endmodule

### hw/rtl/trsa_ctrl.sv
// ----------------------------------------------------------------------------
// trsa_ctrl
// Controller: sequences key derivation after reset and each prime write,
// then modular reduction and square-and-multiply for each item.
// ----------------------------------------------------------------------------
module trsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  trsa_pkg::t_dp_stat i_stat,
    output trsa_pkg::t_dp_cmd  o_cmd
);
    import trsa_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KEY_N;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_ready = 1'b0;
        o_cmd   = '{op: OP_NONE, div_start: 1'b0, div_sel: DIV_XY,
                    mm_start: 1'b0, mm_sel: MM_SQ, result_load: 1'b0};
        unique case (r_state)
            S_KEY_N: begin
                o_cmd.op = OP_CALC_N;
                n_state  = S_KEY_PHI;
            end
            S_KEY_PHI: begin
                o_cmd.op = OP_CALC_PHI;
                n_state  = S_E_INIT;
            end
            S_E_INIT: begin
                o_cmd.op = OP_E_INIT;
                n_state  = i_stat.phi_le2 ? S_D_CHK : S_GCD_INIT;
            end
            S_GCD_INIT: begin
                o_cmd.op = OP_GCD_INIT;
                n_state  = S_GCD_TEST;
            end
            S_GCD_TEST: begin
                if (i_stat.y_zero) begin
                    if (i_stat.x_one) begin
                        n_state = S_D_CHK;
                    end else begin
                        o_cmd.op = OP_E_NEXT;
                        n_state  = S_GCD_INIT;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_GCD_STEP;
                    n_state  = S_GCD_TEST;
                end
            end
            S_D_CHK: begin
                if (i_stat.phi_le1) begin
                    o_cmd.op = OP_D_ZERO;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_INV_INIT;
                    n_state  = S_INV_TEST;
                end
            end
            S_INV_TEST: begin
                if (i_stat.y_zero) begin
                    o_cmd.op = OP_INV_DONE;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_INV_DIV;
                end
            end
            S_INV_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mm_start = 1'b1;
                    o_cmd.mm_sel   = MM_INV;
                    n_state        = S_INV_MUL;
                end
            end
            S_INV_MUL: begin
                if (i_stat.mm_done) begin
                    o_cmd.op = OP_INV_STEP;
                    n_state  = S_INV_TEST;
                end
            end
            S_IDLE: begin
                o_ready = !i_stat.cfg_hit;
                if (!i_stat.cfg_hit && i_valid) begin
                    o_cmd.op = OP_ITEM_LOAD;
                    n_state  = S_ITEM;
                end
            end
            S_ITEM: begin
                if (i_stat.n_gt1) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_VAL;
                    n_state         = S_RED_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RED_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_EXP_INIT;
                    n_state  = S_BIT;
                end
            end
            S_BIT: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_DONE;
                end else if (!i_stat.started) begin
                    o_cmd.op = OP_EXP_FIRST;
                end else begin
                    o_cmd.mm_start = 1'b1;
                    o_cmd.mm_sel   = MM_SQ;
                    n_state        = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (i_stat.mm_done) begin
                    o_cmd.op = OP_ACC_MM;
                    n_state  = S_MB_CHK;
                end
            end
            S_MB_CHK: begin
                if (i_stat.exp_bit) begin
                    o_cmd.mm_start = 1'b1;
                    o_cmd.mm_sel   = MM_BASE;
                    n_state        = S_MB_WAIT;
                end else begin
                    o_cmd.op = OP_EXP_SHIFT;
                    n_state  = S_BIT;
                end
            end
            S_MB_WAIT: begin
                if (i_stat.mm_done) begin
                    o_cmd.op = OP_ACC_MM;
                    n_state  = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.op = OP_EXP_SHIFT;
                n_state  = S_BIT;
            end
            S_DONE: begin
                // load output once the previous result is gone or leaving
                if (!r_valid || i_ready) begin
                    o_cmd.result_load = 1'b1;
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_KEY_N;
            end
        endcase
        // prime write restarts key derivation
        if (i_stat.cfg_hit) begin
            n_state = S_KEY_N;
        end
    end

    assign o_valid = r_valid;

endmodule

### hw/rtl/textbook_rsa_modexp.sv
// Per item: the input value is reduced modulo n, then E modular multiplies follow,
// W = MOD_BITS, E the number of modular multiplies (a square per exponent bit after the
// leading one plus a multiply per set bit among them, up to 2*(W-1)); the multiplies
// run on the bit-serial modular multiplier; for n <= 1 the item skips both and gives 0.
// Throughput: one item at a time; a finished result waits in the output register.
// Reset (synchronous, active low) loads primes 61 and 53 and derives n, phi, e, d;
// input ready stays low while keys are derived, after reset and after a prime write.
// ----------------------------------------------------------------------------
// textbook_rsa_modexp
// Textbook rsa: keys derived from two configured primes, then modular
// exponentiation of each input value with the public or private exponent.
// ----------------------------------------------------------------------------
module textbook_rsa_modexp #(
    parameter int PRIME_BITS = trsa_pkg::PRIME_BITS_DEF,
    parameter int MOD_BITS   = trsa_pkg::MOD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trsa_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [PRIME_BITS-1:0]              i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_operation,
    input  logic [trsa_pkg::VALUE_BITS-1:0]    i_value,
    input  logic                               i_last_in_message,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_result_value,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_public_exponent,
    output logic [trsa_pkg::VALUE_BITS-1:0]    o_private_exponent,
    output logic                               o_last_of_message
);
    import trsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    trsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // arithmetic and key storage
    trsa_dp #(
        .PRIME_BITS (PRIME_BITS),
        .MOD_BITS   (MOD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_value            (i_value),
        .i_last_in_message  (i_last_in_message),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_result_value     (o_result_value),
        .o_public_exponent  (o_public_exponent),
        .o_private_exponent (o_private_exponent),
        .o_last_of_message  (o_last_of_message)
    );

endmodule

### bench/tb_textbook_rsa_modexp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_textbook_rsa_modexp
// Drives encrypt and decrypt transfers through the rsa exponentiation block
// under several prime settings. A local key derivation and modular power
// predict every result, and a monitor checks each field in order.
// ----------------------------------------------------------------------------
module tb_textbook_rsa_modexp;
    import trsa_pkg::*;

    localparam int          CLK_HALF   = 5;
    localparam longint      CYCLE_CAP  = 40_000_000;
    localparam int          DRAIN_WAIT = 60;
    localparam int          PHASE_ITEMS = 135;
    // indexes past the register list
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam logic OPC_ENCRYPT = 1'b0;
    localparam logic OPC_DECRYPT = 1'b1;

    typedef struct {
        logic        op;
        logic [31:0] value;
        logic        last;
    } t_word;

    typedef struct {
        logic [31:0] result;
        logic [31:0] pub_exp;
        logic [31:0] priv_exp;
        logic        last;
    } t_cipher_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_last_in_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_value;
    logic [31:0] o_public_exponent;
    logic [31:0] o_private_exponent;
    logic        o_last_of_message;

    // key material mirrored from the configured primes
    longint unsigned key_p, key_q, key_n, key_phi, key_e, key_d;

    t_word       word_queue[$];
    t_cipher_out cipher_queue[$];
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          quiet_mode = 1'b0;
    int          mismatches = 0;
    longint      cycles = 0;

    textbook_rsa_modexp i_dut (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic longint unsigned inverse_mod(longint unsigned x, longint unsigned m);
        longint r0, r1, t0, t1, qt, tmp;
        r0 = m;
        r1 = x % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            tmp = r0 - qt * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - qt * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1) return 0;
        if (t0 < 0) t0 = t0 + m;
        return t0 % m;
    endfunction

    function automatic longint unsigned power_mod(longint unsigned base,
                                                  longint unsigned ex,
                                                  longint unsigned m);
        longint unsigned acc;
        if (m <= 1) return 0;
        base = base % m;
        acc = 1;
        for (int b = 31; b >= 0; b--) begin
            acc = (acc * acc) % m;
            if (ex[b]) acc = (acc * base) % m;
        end
        return acc;
    endfunction

    // n, phi, e and d from the current primes
    function automatic void derive_keys();
        longint unsigned pm, qm, i;
        pm = (key_p >= 2) ? key_p - 1 : 0;
        qm = (key_q >= 2) ? key_q - 1 : 0;
        key_n = (key_p * key_q) & 64'hFFFF_FFFF;
        key_phi = (pm * qm) & 64'hFFFF_FFFF;
        if (key_phi <= 2) begin
            key_e = 2;
        end else begin
            i = 2;
            while (i < key_phi && gcd64(key_phi, i) != 1) i++;
            key_e = i;
        end
        key_d = (key_phi <= 1) ? 0 : inverse_mod(key_e, key_phi);
    endfunction

    function automatic t_cipher_out predict_cipher(t_word w);
        t_cipher_out c;
        c.result   = 32'(power_mod(w.value, (w.op == OPC_DECRYPT) ? key_d : key_e, key_n));
        c.pub_exp  = 32'(key_e);
        c.priv_exp = 32'(key_d);
        c.last     = w.last;
        return c;
    endfunction

    // mostly short gaps, some long, none in quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_word rand_word(bit below_n);
        t_word w;
        w.op = 1'($urandom_range(0, 1));
        w.value = $urandom();
        if (below_n && key_n > 1) w.value = 32'(w.value % key_n);
        w.last = $urandom_range(0, 3) == 0;
        return w;
    endfunction

    // input side driver, fed from word_queue
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w.op = i_operation;
                w.value = i_value;
                w.last = i_last_in_message;
                cipher_queue.push_back(predict_cipher(w));
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (word_queue.size() > 0) begin
                    w = word_queue.pop_front();
                    i_operation <= w.op;
                    i_value <= w.value;
                    i_last_in_message <= w.last;
                    i_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side monitor with random back pressure
    always @(posedge i_clk) begin
        t_cipher_out c;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cipher_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    c = cipher_queue.pop_front();
                    if (o_result_value !== c.result || o_public_exponent !== c.pub_exp
                        || o_private_exponent !== c.priv_exp
                        || o_last_of_message !== c.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp res %0d e %0d d %0d last %0b, got %0d %0d %0d %0b",
                                     c.result, c.pub_exp, c.priv_exp, c.last, o_result_value,
                                     o_public_exponent, o_private_exponent, o_last_of_message);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    task automatic wait_idle();
        while (word_queue.size() != 0 || i_valid || cipher_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == REG_P) key_p = 64'(data);
        else if (idx == REG_Q) key_q = 64'(data);
        derive_keys();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random(int count);
        repeat (count) word_queue.push_back(rand_word(1'($urandom_range(0, 1))));
    endtask

    task automatic push_word(logic op, logic [31:0] value, logic last);
        t_word w;
        w.op = op;
        w.value = value;
        w.last = last;
        word_queue.push_back(w);
    endtask

    // stimulus phases
    initial begin
        logic [15:0] prime_list[10][2];
        key_p = RESET_P;
        key_q = RESET_Q;
        derive_keys();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset keys: value extremes, both operations
        quiet_mode = 1'b1;
        push_word(OPC_ENCRYPT, 32'd0, 1'b0);
        push_word(OPC_DECRYPT, 32'd0, 1'b1);
        push_word(OPC_ENCRYPT, 32'd1, 1'b0);
        push_word(OPC_DECRYPT, 32'd1, 1'b0);
        push_word(OPC_ENCRYPT, 32'hFFFF_FFFF, 1'b1);
        push_word(OPC_DECRYPT, 32'hFFFF_FFFF, 1'b0);
        push_word(OPC_ENCRYPT, 32'd3232, 1'b0);
        push_word(OPC_DECRYPT, 32'd3232, 1'b0);
        push_word(OPC_ENCRYPT, 32'd3233, 1'b1);
        push_word(OPC_DECRYPT, 32'd3234, 1'b0);
        push_word(OPC_ENCRYPT, 32'h8000_0000, 1'b0);
        push_word(OPC_DECRYPT, 32'h5555_5555, 1'b1);
        push_word(OPC_ENCRYPT, 32'hAAAA_AAAA, 1'b0);
        wait_idle();
        quiet_mode = 1'b0;
        load_random(PHASE_ITEMS);
        wait_idle();

        // writes past the register list leave the keys alone
        write_reg(REG_SPARE_A, 16'd7);
        write_reg(REG_SPARE_B, 16'hFFFF);
        push_word(OPC_DECRYPT, 32'd65, 1'b1);
        load_random(20);
        wait_idle();

        // prime below two, modulus zero or one, no inverse, largest primes
        prime_list[0] = '{16'd0, 16'd53};
        prime_list[1] = '{16'd1, 16'd1};
        prime_list[2] = '{16'd2, 16'd3};
        prime_list[3] = '{16'd2, 16'd2};
        prime_list[4] = '{16'd3, 16'd3};
        prime_list[5] = '{16'hFFFF, 16'hFFFF};
        prime_list[6] = '{16'd65521, 16'd65519};
        prime_list[7] = '{16'd1, 16'd65535};
        prime_list[8] = '{16'($urandom()), 16'($urandom())};
        prime_list[9] = '{16'($urandom_range(2, 400)), 16'($urandom_range(2, 400))};
        for (int k = 0; k < 10; k++) begin
            write_reg(REG_P, prime_list[k][0]);
            write_reg(REG_Q, prime_list[k][1]);
            quiet_mode = (k % 4 == 1);
            push_word(OPC_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
            push_word(OPC_DECRYPT, 32'd0, 1'b1);
            load_random(PHASE_ITEMS - 20);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && cipher_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
